// ===== rtl/mme_pkg.sv =====
`timescale 1ns / 1ps

package mme_pkg;

   // fixed field widths
   localparam int ACTION_WIDTH = 2;
   localparam int INDEX_WIDTH  = 3;
   localparam int VALUE_WIDTH  = 16;
   localparam int PROD_WIDTH   = 40;
   localparam int SIZE_WIDTH   = 4;
   localparam int CSR_IDX_WIDTH = 2;

   // request actions
   localparam logic [ACTION_WIDTH-1:0] ACT_WRITE_A = 2'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_WRITE_B = 2'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_READ    = 2'd2;

   // response status codes
   localparam logic STAT_OK    = 1'b0;
   localparam logic STAT_RANGE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ROWS_OF_A  = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_INNER_SIZE = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_COLS_OF_B  = 2'd2;

   localparam logic [SIZE_WIDTH-1:0] SIZE_RESET = 4'd8;

   typedef struct packed {
      logic [ACTION_WIDTH-1:0]       action;
      logic [INDEX_WIDTH-1:0]        row;
      logic [INDEX_WIDTH-1:0]        col;
      logic signed [VALUE_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [PROD_WIDTH-1:0] product;
      logic                         status;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic issue;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic start_mac;
      logic last_k;
      logic pipe_busy;
   } stat_type;

endpackage

// ===== rtl/mme_datapath.sv =====
`timescale 1ns / 1ps

module mme_datapath #(
   parameter int MAX_DIM    = 8,
   parameter int ELEM_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mme_pkg::req_type                      req_data,
   input  logic                                  csr_write_en,
   input  logic [mme_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  logic [mme_pkg::SIZE_WIDTH-1:0]        csr_wdata,
   input  mme_pkg::cmd_type                      cmd,
   output mme_pkg::stat_type                     status,
   output mme_pkg::rsp_type                      rsp_data
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int AW     = $clog2(DEPTH);
   localparam int MUL_W  = 2 * ELEM_WIDTH;
   localparam logic [mme_pkg::SIZE_WIDTH-1:0] SIZE_CAP =
      mme_pkg::SIZE_WIDTH'((MAX_DIM > 15) ? 15 : MAX_DIM);

   logic [mme_pkg::SIZE_WIDTH-1:0] rows_ff, rows_in;
   logic [mme_pkg::SIZE_WIDTH-1:0] inner_ff, inner_in;
   logic [mme_pkg::SIZE_WIDTH-1:0] cols_ff, cols_in;
   logic [mme_pkg::SIZE_WIDTH-1:0] eff_nr, eff_nk, eff_nc;
   logic [mme_pkg::SIZE_WIDTH-1:0] row_x, col_x;
   logic                           in_a, in_b, in_p, req_ok;
   logic                           wr_a, wr_b;
   logic [AW-1:0]                  wr_addr, rd_a_addr, rd_b_addr;
   logic [ELEM_WIDTH-1:0]          wr_val;
   logic [mme_pkg::VALUE_WIDTH-1:0] value_bits;

   logic [ELEM_WIDTH-1:0]          mem_a [DEPTH];
   logic [ELEM_WIDTH-1:0]          mem_b [DEPTH];

   logic [mme_pkg::INDEX_WIDTH-1:0] row_ff, col_ff;
   logic [mme_pkg::SIZE_WIDTH-1:0]  k_ff, k_in;
   logic signed [ELEM_WIDTH-1:0]    a_rd_ff, b_rd_ff;
   logic                            rd_vld_ff, mul_vld_ff;
   logic signed [MUL_W-1:0]         mul_ff;
   logic signed [mme_pkg::PROD_WIDTH-1:0] acc_ff, acc_in;
   logic                            stat_ff;
   mme_pkg::rsp_type                rsp_ff;

   // size registers
   always_comb begin
      rows_in  = rows_ff;
      inner_in = inner_ff;
      cols_in  = cols_ff;
      if (csr_write_en) begin
         case (csr_index)
            mme_pkg::CSR_ROWS_OF_A:  rows_in  = csr_wdata;
            mme_pkg::CSR_INNER_SIZE: inner_in = csr_wdata;
            mme_pkg::CSR_COLS_OF_B:  cols_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= mme_pkg::SIZE_RESET;
         inner_ff <= mme_pkg::SIZE_RESET;
         cols_ff  <= mme_pkg::SIZE_RESET;
      end else begin
         rows_ff  <= rows_in;
         inner_ff <= inner_in;
         cols_ff  <= cols_in;
      end
   end

   // sizes clamp at the store dimension, at most 15
   assign eff_nr = (rows_ff  > SIZE_CAP) ? SIZE_CAP : rows_ff;
   assign eff_nk = (inner_ff > SIZE_CAP) ? SIZE_CAP : inner_ff;
   assign eff_nc = (cols_ff  > SIZE_CAP) ? SIZE_CAP : cols_ff;

   // range check of the incoming request
   assign row_x = {1'b0, req_data.row};
   assign col_x = {1'b0, req_data.col};
   assign in_a  = (row_x < eff_nr) && (col_x < eff_nk);
   assign in_b  = (row_x < eff_nk) && (col_x < eff_nc);
   assign in_p  = (row_x < eff_nr) && (col_x < eff_nc);

   always_comb begin
      case (req_data.action)
         mme_pkg::ACT_WRITE_A: req_ok = in_a;
         mme_pkg::ACT_WRITE_B: req_ok = in_b;
         mme_pkg::ACT_READ:    req_ok = in_p;
         default:              req_ok = 1'b0;
      endcase
   end

   assign wr_a = cmd.capture && (req_data.action == mme_pkg::ACT_WRITE_A) && in_a;
   assign wr_b = cmd.capture && (req_data.action == mme_pkg::ACT_WRITE_B) && in_b;

   assign value_bits = req_data.value;
   assign wr_val     = ELEM_WIDTH'(value_bits);
   assign wr_addr    = AW'(int'(req_data.row) * MAX_DIM + int'(req_data.col));
   assign rd_a_addr  = AW'(int'(row_ff) * MAX_DIM + int'(k_ff));
   assign rd_b_addr  = AW'(int'(k_ff) * MAX_DIM + int'(col_ff));

   // element stores, one write or one read per cycle each
   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[wr_addr] <= wr_val;
      end
      if (cmd.issue) begin
         a_rd_ff <= mem_a[rd_a_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         mem_b[wr_addr] <= wr_val;
      end
      if (cmd.issue) begin
         b_rd_ff <= mem_b[rd_b_addr];
      end
   end

   // request capture and inner index
   always_comb begin
      k_in = k_ff;
      if (cmd.capture) begin
         k_in = '0;
      end else if (cmd.issue) begin
         k_in = k_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      if (cmd.capture) begin
         row_ff  <= req_data.row;
         col_ff  <= req_data.col;
         stat_ff <= req_ok ? mme_pkg::STAT_OK : mme_pkg::STAT_RANGE;
      end
   end

   // multiply then accumulate, wrapping at the product width
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= cmd.issue;
         mul_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= a_rd_ff * b_rd_ff;
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.capture) begin
         acc_in = '0;
      end else if (mul_vld_ff) begin
         acc_in = acc_ff + mme_pkg::PROD_WIDTH'(mul_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.product <= acc_ff;
         rsp_ff.status  <= stat_ff;
      end
   end

   assign rsp_data         = rsp_ff;
   assign status.start_mac = (req_data.action == mme_pkg::ACT_READ) && in_p &&
                             (eff_nk != '0);
   assign status.last_k    = ((k_ff + 1'b1) == eff_nk);
   assign status.pipe_busy = rd_vld_ff || mul_vld_ff;

   // a new request only lands on an empty multiply pipeline
   a_capture_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> !rd_vld_ff && !mul_vld_ff)
      else $error("request captured while multiply pipeline busy");

   // the result is taken only after the last product was summed
   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !rd_vld_ff && !mul_vld_ff)
      else $error("result loaded before accumulation finished");

endmodule

// ===== rtl/mme_ctrl.sv =====
`timescale 1ns / 1ps

module mme_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  mme_pkg::stat_type  status,
   output mme_pkg::cmd_type   cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // sequencing of one request
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = status.start_mac ? ST_RUN : ST_DONE;
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            if (status.last_k) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // a good read with a nonzero inner size goes to the multiply loop
   a_start_run: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && status.start_mac |=> state_ff == ST_RUN)
      else $error("read did not enter the multiply loop");

   // drain ends as soon as the pipeline is empty
   a_drain_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN && !status.pipe_busy |=> state_ff == ST_DONE)
      else $error("drain did not finish on empty pipeline");

   // a new result appears only from the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside done state");

endmodule

// ===== rtl/matrix_multiply_engine.sv =====
`timescale 1ns / 1ps
// writes and rejected requests: result loaded in the done state once the
//   receiver has taken the previous one; next request taken back in idle
// reads: one multiply-accumulate per cycle through registered store reads,
//   a registered multiplier and the accumulator; one read at a time
// reset: size registers return to 8, no result pending, stores keep old contents
module matrix_multiply_engine #(
   parameter int MAX_DIM    = 8,
   parameter int ELEM_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  mme_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output mme_pkg::rsp_type                  rsp_data,
   input  logic                              csr_write_en,
   input  logic [mme_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [mme_pkg::SIZE_WIDTH-1:0]    csr_wdata
);

   mme_pkg::cmd_type  cmd;
   mme_pkg::stat_type status;

   // sequencer
   mme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // stores, multiply-accumulate and size registers
   mme_datapath #(
      .MAX_DIM    (MAX_DIM),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .status       (status),
      .rsp_data     (rsp_data)
   );

endmodule

// ===== test/matrix_multiply_engine_test.sv =====
`timescale 1ns / 1ps

module matrix_multiply_engine_test;

   localparam int MAX_DIM       = 8;
   localparam int STORE_DEPTH   = MAX_DIM * MAX_DIM;
   localparam int SETTLE_CYCLES = 30;
   localparam int HOLD_CYCLES   = 300;
   localparam logic [mme_pkg::ACTION_WIDTH-1:0] ACT_UNUSED = 2'd3;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   mme_pkg::req_type                  req_data = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   mme_pkg::rsp_type                  rsp_data;
   logic                              csr_write_en = 1'b0;
   logic [mme_pkg::CSR_IDX_WIDTH-1:0] csr_index = mme_pkg::CSR_ROWS_OF_A;
   logic [mme_pkg::SIZE_WIDTH-1:0]    csr_wdata = '0;

   // matrix contents and sizes as the block should hold them
   logic signed [mme_pkg::VALUE_WIDTH-1:0] a_matrix [STORE_DEPTH];
   logic signed [mme_pkg::VALUE_WIDTH-1:0] b_matrix [STORE_DEPTH];
   bit                                     a_loaded [STORE_DEPTH];
   bit                                     b_loaded [STORE_DEPTH];
   logic [mme_pkg::SIZE_WIDTH-1:0]         rows_setting  = mme_pkg::SIZE_RESET;
   logic [mme_pkg::SIZE_WIDTH-1:0]         inner_setting = mme_pkg::SIZE_RESET;
   logic [mme_pkg::SIZE_WIDTH-1:0]         cols_setting  = mme_pkg::SIZE_RESET;

   mme_pkg::rsp_type pending_answers [$];
   int               error_count = 0;

   // idling controls
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_request   = 0;
   int hold_seen      = 0;
   int hold_left      = 0;

   matrix_multiply_engine uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_seen != hold_request) begin
         hold_seen <= hold_request;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // compare each response transfer with the oldest predicted answer
   always @(posedge clock) begin
      mme_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: response with none expected: product %0d, status %0d",
                     $time, rsp_data.product, rsp_data.status);
            error_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_data.product !== want.product) begin
               $display("%0t: product mismatch: expected %0d, actual %0d",
                        $time, want.product, rsp_data.product);
               error_count++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, want.status, rsp_data.status);
               error_count++;
            end
         end
      end
   end

   // run limit
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int effective_size(logic [mme_pkg::SIZE_WIDTH-1:0] setting);
      return (setting > MAX_DIM) ? MAX_DIM : int'(setting);
   endfunction

   // apply one request to the matrix copies and work out its response
   function automatic mme_pkg::rsp_type compute_answer(mme_pkg::req_type item);
      mme_pkg::rsp_type                      answer;
      int                                    n_rows;
      int                                    n_inner;
      int                                    n_cols;
      int                                    k;
      logic signed [mme_pkg::PROD_WIDTH-1:0] acc;
      n_rows  = effective_size(rows_setting);
      n_inner = effective_size(inner_setting);
      n_cols  = effective_size(cols_setting);
      answer.product = '0;
      answer.status  = mme_pkg::STAT_RANGE;
      case (item.action)
         mme_pkg::ACT_WRITE_A: begin
            if (item.row < n_rows && item.col < n_inner) begin
               a_matrix[item.row * MAX_DIM + item.col] = item.value;
               a_loaded[item.row * MAX_DIM + item.col] = 1'b1;
               answer.status = mme_pkg::STAT_OK;
            end
         end
         mme_pkg::ACT_WRITE_B: begin
            if (item.row < n_inner && item.col < n_cols) begin
               b_matrix[item.row * MAX_DIM + item.col] = item.value;
               b_loaded[item.row * MAX_DIM + item.col] = 1'b1;
               answer.status = mme_pkg::STAT_OK;
            end
         end
         mme_pkg::ACT_READ: begin
            if (item.row < n_rows && item.col < n_cols) begin
               acc = '0;
               for (k = 0; k < n_inner; k++)
                  acc = acc + a_matrix[item.row * MAX_DIM + k] *
                              b_matrix[k * MAX_DIM + item.col];
               answer.product = acc;
               answer.status  = mme_pkg::STAT_OK;
            end
         end
         default: ;
      endcase
      return answer;
   endfunction

   function automatic mme_pkg::req_type make_request(
         logic [mme_pkg::ACTION_WIDTH-1:0] action, int row, int col,
         logic [mme_pkg::VALUE_WIDTH-1:0] value);
      mme_pkg::req_type item;
      item.action = action;
      item.row    = mme_pkg::INDEX_WIDTH'(row);
      item.col    = mme_pkg::INDEX_WIDTH'(col);
      item.value  = value;
      return item;
   endfunction

   function automatic logic [mme_pkg::VALUE_WIDTH-1:0] random_value();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'hffff;
         default: return mme_pkg::VALUE_WIDTH'($urandom());
      endcase
   endfunction

   // mostly inside the configured size, sometimes anywhere
   function automatic int pick_index(int limit);
      if (limit == 0 || $urandom_range(6) == 0)
         return $urandom_range(7);
      return $urandom_range(limit - 1);
   endfunction

   // random request; a read that would use an unloaded element loads it instead
   function automatic mme_pkg::req_type random_request();
      mme_pkg::req_type item;
      int               n_rows;
      int               n_inner;
      int               n_cols;
      int               roll;
      int               k;
      n_rows  = effective_size(rows_setting);
      n_inner = effective_size(inner_setting);
      n_cols  = effective_size(cols_setting);
      roll = $urandom_range(99);
      if (roll < 35)
         item = make_request(mme_pkg::ACT_WRITE_A, pick_index(n_rows),
                             pick_index(n_inner), random_value());
      else if (roll < 70)
         item = make_request(mme_pkg::ACT_WRITE_B, pick_index(n_inner),
                             pick_index(n_cols), random_value());
      else if (roll < 95)
         item = make_request(mme_pkg::ACT_READ, pick_index(n_rows),
                             pick_index(n_cols), random_value());
      else
         item = make_request(ACT_UNUSED, $urandom_range(7), $urandom_range(7),
                             random_value());
      if (item.action == mme_pkg::ACT_READ && item.row < n_rows && item.col < n_cols) begin
         for (k = 0; k < n_inner; k++) begin
            if (!a_loaded[item.row * MAX_DIM + k])
               return make_request(mme_pkg::ACT_WRITE_A, item.row, k, random_value());
            if (!b_loaded[k * MAX_DIM + item.col])
               return make_request(mme_pkg::ACT_WRITE_B, k, item.col, random_value());
         end
      end
      return item;
   endfunction

   // offer one request, with a random gap first, and predict it on transfer
   task automatic send_request(mme_pkg::req_type item);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      pending_answers.insert(pending_answers.size(), compute_answer(item));
   endtask

   // stop offering and wait until every predicted answer has come back
   task automatic wait_for_answers();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   // write all three size registers while the block is idle
   task automatic program_sizes(int rows, int inner, int cols);
      wait_for_answers();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= mme_pkg::CSR_ROWS_OF_A;
      csr_wdata    <= mme_pkg::SIZE_WIDTH'(rows);
      @(posedge clock);
      rows_setting = mme_pkg::SIZE_WIDTH'(rows);
      csr_index    <= mme_pkg::CSR_INNER_SIZE;
      csr_wdata    <= mme_pkg::SIZE_WIDTH'(inner);
      @(posedge clock);
      inner_setting = mme_pkg::SIZE_WIDTH'(inner);
      csr_index    <= mme_pkg::CSR_COLS_OF_B;
      csr_wdata    <= mme_pkg::SIZE_WIDTH'(cols);
      @(posedge clock);
      cols_setting = mme_pkg::SIZE_WIDTH'(cols);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_idling(int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct <= recv_pct;
   endtask

   // load one row of A and one column of B, then read their dot product
   task automatic send_dot_product_run();
      int n_rows;
      int n_inner;
      int n_cols;
      int r;
      int c;
      int k;
      n_rows  = effective_size(rows_setting);
      n_inner = effective_size(inner_setting);
      n_cols  = effective_size(cols_setting);
      if (n_rows == 0 || n_inner == 0 || n_cols == 0)
         return;
      r = $urandom_range(n_rows - 1);
      c = $urandom_range(n_cols - 1);
      for (k = 0; k < n_inner; k++) begin
         send_request(make_request(mme_pkg::ACT_WRITE_A, r, k, random_value()));
         send_request(make_request(mme_pkg::ACT_WRITE_B, k, c, random_value()));
      end
      send_request(make_request(mme_pkg::ACT_READ, r, c, random_value()));
   endtask

   task automatic run_traffic(int count);
      int i;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(7) == 0)
            send_dot_product_run();
         else
            send_request(random_request());
      end
   endtask

   // largest magnitudes at the highest indexes, reads and the unused action
   task automatic test_directed_extremes();
      int k;
      set_idling(0, 0);
      for (k = 0; k < MAX_DIM; k++)
         send_request(make_request(mme_pkg::ACT_WRITE_A, MAX_DIM - 1, k, 16'h8000));
      for (k = 0; k < MAX_DIM; k++)
         send_request(make_request(mme_pkg::ACT_WRITE_B, k, MAX_DIM - 1, 16'h8000));
      send_request(make_request(mme_pkg::ACT_READ, MAX_DIM - 1, MAX_DIM - 1, 16'h0000));
      send_request(make_request(mme_pkg::ACT_WRITE_B, 0, MAX_DIM - 1, 16'h7fff));
      // value field must not matter on a read
      send_request(make_request(mme_pkg::ACT_READ, MAX_DIM - 1, MAX_DIM - 1, 16'hffff));
      send_request(make_request(ACT_UNUSED, MAX_DIM - 1, 0, 16'h7fff));
      send_request(make_request(mme_pkg::ACT_READ, MAX_DIM - 1, MAX_DIM - 1, 16'h5555));
      wait_for_answers();
   endtask

   // size extremes: one, full, above the maximum and zero on each dimension
   task automatic test_size_settings();
      int sweep_rows  [8] = '{1, 8, 15, 0, 4, 2, 8, 1};
      int sweep_inner [8] = '{1, 8, 15, 5, 0, 7, 1, 8};
      int sweep_cols  [8] = '{1, 8, 15, 3, 6, 0, 8, 1};
      int idle_send   [4] = '{0, 71, 0, 38};
      int idle_recv   [4] = '{0, 0, 71, 38};
      int i;
      for (i = 0; i < 8; i++) begin
         program_sizes(sweep_rows[i], sweep_inner[i], sweep_cols[i]);
         set_idling(idle_send[i % 4], idle_recv[i % 4]);
         run_traffic(20);
      end
      wait_for_answers();
   endtask

   // receiver holds off long enough for the block to stall its input
   task automatic test_output_stall();
      int i;
      program_sizes(8, 8, 8);
      set_idling(0, 0);
      hold_request <= hold_request + 1;
      for (i = 0; i < 10; i++)
         send_request(random_request());
      wait_for_answers();
   endtask

   // random traffic under each idling pattern, first at full size, then random sizes
   task automatic test_mixed_traffic();
      int idle_send [4] = '{0, 71, 0, 38};
      int idle_recv [4] = '{0, 0, 71, 38};
      int p;
      for (p = 0; p < 4; p++) begin
         if (p == 0)
            program_sizes(8, 8, 8);
         else
            program_sizes($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8));
         set_idling(idle_send[p], idle_recv[p]);
         run_traffic(25);
      end
      wait_for_answers();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_extremes();
      test_size_settings();
      test_output_stall();
      test_mixed_traffic();
      wait_for_answers();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/mme_pkg.sv
rtl/mme_datapath.sv
rtl/mme_ctrl.sv
rtl/matrix_multiply_engine.sv
test/matrix_multiply_engine_test.sv
